>>> rtl/core/flpr_pkg.sv
// ----------------------------------------------------------------------------
// flpr_pkg
// Shared types and constants for the FIFO/LRU page replacement unit.
// ----------------------------------------------------------------------------
package flpr_pkg;

   // configuration port
   localparam int CSR_W = 3;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_POLICY_MODE   = 1'b0,
      REG_FRAMES_IN_USE = 1'b1
   } flpr_reg_type;

   localparam logic [CSR_W-1:0] FRAMES_IN_USE_RST = 3'd4;

   // replacement policies
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // fault counter
   localparam int FAULT_W = 16;

   // lookup outcome from the frame table
   typedef struct packed {
      logic hit;
      logic evicted;
   } flpr_status_type;

endpackage

>>> rtl/core/fifo_lru_page_replacement.sv
// ----------------------------------------------------------------------------
// fifo_lru_page_replacement
// Page replacement unit with FIFO and LRU policies for one page reference
// per transaction.
// ----------------------------------------------------------------------------
// Each request carries one virtual page number; each response reports hit or
// fault, the frame now holding the page, any evicted page and the saturating
// fault total. Throughput is one transaction per cycle unless the response
// channel stalls; a request passes the input register, then the response
// register. The rate is set by the frame table, whose lookup over all FRAMES
// owners, victim pick and age-rank update are combinational, so the next
// request always sees the state left by the one before. No clearing pass
// follows reset. Write configuration only while idle; this is not enforced.
module fifo_lru_page_replacement
   import flpr_pkg::*;
#(
   parameter int FRAMES = 4,
   parameter int VPAGES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [$clog2(VPAGES)-1:0]     req_page_number,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [$clog2(FRAMES)-1:0]     rsp_frame_index,
   output logic                          rsp_evicted,
   output logic [$clog2(VPAGES)-1:0]     rsp_evicted_page,
   output logic [FAULT_W-1:0]            rsp_fault_count,
   // configuration port
   input  logic                          csr_we,
   input  logic [CSR_ADDR_W-1:0]         csr_addr,
   input  logic [CSR_W-1:0]              csr_wdata
);

   localparam int PW = $clog2(VPAGES);
   localparam int FW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES+1);
   localparam int LW = (CW > CSR_W) ? CW : CSR_W;

   logic              policy_mode_ff;
   logic [CSR_W-1:0]  frames_in_use_ff;
   logic [LW-1:0]     fiu_wide;
   logic [CW-1:0]     limit;

   logic              s1_valid_ff;
   logic [PW-1:0]     s1_page_ff;
   logic [PW-1:0]     page_in;
   logic              s1_adv;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [FW-1:0]     rsp_frame_ff;
   logic              rsp_evicted_ff;
   logic [PW-1:0]     rsp_evicted_page_ff;
   logic [FAULT_W-1:0] fault_ff;
   logic [FAULT_W-1:0] fault_in;

   flpr_status_type   status;
   logic [FW-1:0]     frame;
   logic [PW-1:0]     evicted_page;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_mode_ff   <= POLICY_FIFO;
         frames_in_use_ff <= FRAMES_IN_USE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_POLICY_MODE:   policy_mode_ff   <= csr_wdata[0];
            REG_FRAMES_IN_USE: frames_in_use_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame limit clamped to 1..FRAMES
   assign fiu_wide = LW'(frames_in_use_ff);
   always_comb begin
      if (fiu_wide == '0) begin
         limit = CW'(1);
      end else if (fiu_wide > LW'(FRAMES)) begin
         limit = CW'(FRAMES);
      end else begin
         limit = fiu_wide[CW-1:0];
      end
   end

   // handshake: input stage moves on when the response register is free
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   // fold page numbers beyond VPAGES back into range
   assign page_in = ({1'b0, req_page_number} >= (PW+1)'(VPAGES))
                    ? PW'({1'b0, req_page_number} - (PW+1)'(VPAGES))
                    : req_page_number;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_page_ff <= page_in;
      end
   end

   // frame table lookup and update
   flpr_frame_tbl #(
      .FRAMES (FRAMES),
      .VPAGES (VPAGES)
   ) u_frame_tbl (
      .clock        (clock),
      .reset        (reset),
      .upd          (s1_adv),
      .page         (s1_page_ff),
      .limit        (limit),
      .policy       (policy_mode_ff),
      .status       (status),
      .frame        (frame),
      .evicted_page (evicted_page)
   );

   // saturating fault counter
   always_comb begin
      fault_in = fault_ff;
      if (!status.hit && (fault_ff != '1)) begin
         fault_in = fault_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            fault_ff     <= fault_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_hit_ff          <= status.hit;
         rsp_frame_ff        <= frame;
         rsp_evicted_ff      <= status.evicted;
         rsp_evicted_page_ff <= evicted_page;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_index  = rsp_frame_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fault_count  = fault_ff;

   // a hit never evicts a page
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("hit reported together with an eviction");

   // a fault below saturation bumps the counter by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !status.hit && (fault_ff != '1)) |=>
         (fault_ff == $past(fault_ff) + 1'b1))
      else $error("fault counter did not advance on a page fault");

   // a hit leaves the fault counter untouched
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && status.hit) |=> $stable(fault_ff))
      else $error("fault counter changed on a hit");

   // every transaction leaving the input stage lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("response lost after lookup");

endmodule

>>> rtl/core/flpr_frame_tbl.sv
// ----------------------------------------------------------------------------
// flpr_frame_tbl
// Frame table: per-frame owner page and age rank, fill count, parallel
// lookup of the accessed page, victim pick and rank update.
// ----------------------------------------------------------------------------
module flpr_frame_tbl
   import flpr_pkg::*;
#(
   parameter int FRAMES = 4,
   parameter int VPAGES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              upd,
   input  logic [$clog2(VPAGES)-1:0]         page,
   input  logic [$clog2(FRAMES+1)-1:0]       limit,
   input  logic                              policy,
   output flpr_status_type                   status,
   output logic [$clog2(FRAMES)-1:0]         frame,
   output logic [$clog2(VPAGES)-1:0]         evicted_page
);

   localparam int PW = $clog2(VPAGES);
   localparam int FW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES+1);

   logic [PW-1:0]     owner_ff [FRAMES];
   logic [FW-1:0]     rank_ff  [FRAMES];
   logic [FW-1:0]     rank_in  [FRAMES];
   logic [CW-1:0]     filled_ff;
   logic [CW-1:0]     filled_in;

   logic [FRAMES-1:0] filled_vec;
   logic [FRAMES-1:0] match;
   logic [FW-1:0]     hit_frame;
   logic [FW-1:0]     oldest;
   logic              hit;
   logic              room;
   logic              refresh;
   logic              load;
   logic [FW-1:0]     cur_rank;
   logic [FW-1:0]     newest_rank;

   // parallel compare against every filled frame
   always_comb begin
      for (int f = 0; f < FRAMES; f++) begin
         filled_vec[f] = CW'(f) < filled_ff;
         match[f]      = filled_vec[f] && (owner_ff[f] == page);
      end
   end

   // lowest matching frame and lowest oldest frame
   always_comb begin
      hit_frame = '0;
      oldest    = '0;
      for (int f = FRAMES-1; f >= 0; f--) begin
         if (match[f]) begin
            hit_frame = FW'(f);
         end
         if (filled_vec[f] && (rank_ff[f] == '0)) begin
            oldest = FW'(f);
         end
      end
   end

   assign hit  = |match;
   assign room = filled_ff < limit;

   // frame chosen for this access
   always_comb begin
      if (hit) begin
         frame = hit_frame;
      end else if (room) begin
         frame = filled_ff[FW-1:0];
      end else begin
         frame = oldest;
      end
   end

   assign status.hit     = hit;
   assign status.evicted = !hit && !room;
   assign evicted_page   = status.evicted ? owner_ff[oldest] : '0;

   assign refresh     = (hit && (policy == POLICY_LRU)) || status.evicted;
   assign load        = !hit && room;
   assign cur_rank    = rank_ff[frame];
   assign newest_rank = FW'(filled_ff - 1'b1);

   // rank update: move to newest, or set on first load
   always_comb begin
      for (int f = 0; f < FRAMES; f++) begin
         rank_in[f] = rank_ff[f];
         if (refresh) begin
            if (FW'(f) == frame) begin
               rank_in[f] = newest_rank;
            end else if (filled_vec[f] && (rank_ff[f] > cur_rank)) begin
               rank_in[f] = rank_ff[f] - 1'b1;
            end
         end else if (load && (FW'(f) == frame)) begin
            rank_in[f] = filled_ff[FW-1:0];
         end
      end
   end

   assign filled_in = load ? filled_ff + 1'b1 : filled_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         for (int f = 0; f < FRAMES; f++) begin
            rank_ff[f] <= '0;
         end
      end else if (upd) begin
         filled_ff <= filled_in;
         for (int f = 0; f < FRAMES; f++) begin
            rank_ff[f] <= rank_in[f];
         end
      end
   end

   // owner page of each frame, written on a fault
   always_ff @(posedge clock) begin
      if (upd && !hit) begin
         owner_ff[frame] <= page;
      end
   end

endmodule
